[design/itr_pkg.sv]
// itr_pkg: types and constants shared by the interval timer register block.
// Item and result word layouts, timer state, item kinds and register map.
// No dependencies.
package itr_pkg;

  localparam int DataW  = 16;
  localparam int CountW = 32;

  // item kinds
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // register map
  localparam logic [2:0] ADDR_STATUS  = 3'd0;
  localparam logic [2:0] ADDR_CONTROL = 3'd1;
  localparam logic [2:0] ADDR_PER_LO  = 3'd2;
  localparam logic [2:0] ADDR_PER_HI  = 3'd3;
  localparam logic [2:0] ADDR_SNAP_LO = 3'd4;
  localparam logic [2:0] ADDR_SNAP_HI = 3'd5;

  // control register bits
  localparam int CTRL_IRQ_EN = 0;
  localparam int CTRL_CONT   = 1;
  localparam int CTRL_START  = 2;
  localparam int CTRL_STOP   = 3;

  typedef struct packed {
    logic [1:0]       func;
    logic [2:0]       reg_addr;
    logic [DataW-1:0] write_data;
  } itr_in_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             irq_level;
  } itr_out_t;

  typedef struct packed {
    logic              running;
    logic              timed_out;
    logic              irq_enable;
    logic              continuous;
    logic [CountW-1:0] period_value;
    logic [CountW-1:0] counter;
    logic [CountW-1:0] snapshot;
  } itr_state_t;

endpackage

[design/itr_core.sv]
// itr_core: next-state and result logic for one timer word (tick, read, write).
// Purely combinational; depends on itr_pkg.
module itr_core
  import itr_pkg::*;
(
  input  itr_state_t state_i,
  input  itr_in_t    item_i,
  output itr_state_t state_o,
  output itr_out_t   result_o
);

  logic [DataW-1:0] rd;

  always_comb begin
    state_o = state_i;
    rd      = '0;
    case (item_i.func)
      FUNC_TICK: begin
        if (state_i.running) begin
          if (state_i.counter != '0) begin
            state_o.counter = state_i.counter - CountW'(1);
          end else begin
            state_o.counter   = state_i.period_value;
            state_o.timed_out = 1'b1;
            state_o.running   = state_i.continuous;
          end
        end
      end
      FUNC_READ: begin
        case (item_i.reg_addr)
          ADDR_STATUS:  rd = {{(DataW-2){1'b0}}, state_i.running, state_i.timed_out};
          ADDR_CONTROL: rd = {{(DataW-2){1'b0}}, state_i.continuous, state_i.irq_enable};
          ADDR_PER_LO:  rd = state_i.period_value[DataW-1:0];
          ADDR_PER_HI:  rd = state_i.period_value[CountW-1:DataW];
          ADDR_SNAP_LO: rd = state_i.snapshot[DataW-1:0];
          ADDR_SNAP_HI: rd = state_i.snapshot[CountW-1:DataW];
          default:      rd = '0;
        endcase
      end
      FUNC_WRITE: begin
        case (item_i.reg_addr)
          ADDR_STATUS: state_o.timed_out = 1'b0;
          ADDR_CONTROL: begin
            state_o.irq_enable = item_i.write_data[CTRL_IRQ_EN];
            state_o.continuous = item_i.write_data[CTRL_CONT];
            state_o.running    = (state_i.running & ~item_i.write_data[CTRL_STOP])
                               | item_i.write_data[CTRL_START];
          end
          ADDR_PER_LO: begin
            state_o.period_value = {state_i.period_value[CountW-1:DataW], item_i.write_data};
            state_o.counter      = {state_i.period_value[CountW-1:DataW], item_i.write_data};
          end
          ADDR_PER_HI: begin
            state_o.period_value = {item_i.write_data, state_i.period_value[DataW-1:0]};
            state_o.counter      = {item_i.write_data, state_i.period_value[DataW-1:0]};
          end
          ADDR_SNAP_LO, ADDR_SNAP_HI: state_o.snapshot = state_i.counter;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign result_o.read_data = rd;
  assign result_o.irq_level = state_o.irq_enable & state_o.timed_out;

endmodule

[design/interval_timer_regs.sv]
// interval_timer_regs: 32-bit down-counting interval timer behind six 16-bit registers.
// Top level: input word register, timer state, result register.
// Depends on itr_pkg and itr_core.
//
// Usage
//   in_*  : one word per handshake (in_valid & in_ready): a tick, a register
//           read or a register write, selected by func.
//   out_* : exactly one result word per input word, in order: read_data
//           (zero unless a read) and irq_level (irq enable AND timeout after
//           that word has taken effect).
//   Registers: an accepted word passes through two registers (input word,
//   result) before its result shows on out_valid.
//   Throughput: one word per clock, sustained, while out_ready stays high.
//   The timer state updates as a word moves from the input register to the
//   result register, so state order always matches word order.
//   Stall: when out_ready is low the result holds; the input register still
//   takes one more word, then in_ready drops until the result is taken.
//   Reset (rst_n low, synchronous): both registers empty, timer stopped,
//   flags clear, period, count and snapshot zero.
module interval_timer_regs
  import itr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  itr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output itr_out_t out_data
);

  // input word register
  logic       s1_valid_r;
  itr_in_t    s1_word_r;

  // result register
  logic       out_valid_r;
  itr_out_t   out_word_r;

  // timer state
  itr_state_t state_r;
  itr_state_t state_nxt;
  itr_out_t   result_nxt;

  logic       s1_advance;

  // the input word moves on whenever the result slot is free or being emptied
  assign s1_advance = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready   = ~s1_valid_r | s1_advance;

  itr_core u_core (
    .state_i  (state_r),
    .item_i   (s1_word_r),
    .state_o  (state_nxt),
    .result_o (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_word_r <= result_nxt;
    end
  end

  // timer state commits once per word, as it leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_advance) begin
      state_r <= state_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule
